// File: rtl/acm_pkg.sv
package acm_pkg;

	localparam int unsigned SAMPLE_W   = 10;
	localparam int unsigned SUM_W      = 16;
	localparam int unsigned AVG_W      = 10;
	localparam int unsigned CNT_W      = 7;
	localparam int unsigned FLAG_W     = 8;
	localparam int unsigned CHAN_W     = 3;
	localparam int unsigned NCH_W      = 4;
	localparam int unsigned NCMP_W     = 5;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 10;

	localparam int unsigned DEF_MAX_CHANNELS = 8;
	localparam int unsigned DEF_AVG_SHIFT    = 6;

	localparam logic [NCH_W-1:0]    RST_CHANNELS   = 4'd5;
	localparam logic [SAMPLE_W-1:0] RST_LOW_LIMIT  = 10'd5;
	localparam logic [SAMPLE_W-1:0] RST_HIGH_LIMIT = 10'd1000;
	localparam logic [CNT_W-1:0]    RST_FAULT_CNT  = 7'd100;
	localparam logic [FLAG_W-1:0]   RST_FAULT_MASK = 8'd12;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHANNELS_IN_USE = 3'd0,
		REG_LOW_LIMIT       = 3'd1,
		REG_HIGH_LIMIT      = 3'd2,
		REG_FAULT_COUNT     = 3'd3,
		REG_FAULT_MASK      = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [NCH_W-1:0]    channels_in_use;
		logic [SAMPLE_W-1:0] low_limit;
		logic [SAMPLE_W-1:0] high_limit;
		logic [CNT_W-1:0]    fault_count;
		logic [FLAG_W-1:0]   fault_mask;
	} cfg_t;

	typedef struct packed {
		logic [CHAN_W-1:0]   channel;
		logic [SAMPLE_W-1:0] sample_echo;
		logic                average_updated;
		logic [AVG_W-1:0]    average;
		logic [FLAG_W-1:0]   fault_flags;
		logic                calc_ready;
	} res_t;

endpackage

// File: rtl/acm_cfg_regs.sv
module acm_cfg_regs import acm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channels_in_use <= RST_CHANNELS;
			cfg_q.low_limit       <= RST_LOW_LIMIT;
			cfg_q.high_limit      <= RST_HIGH_LIMIT;
			cfg_q.fault_count     <= RST_FAULT_CNT;
			cfg_q.fault_mask      <= RST_FAULT_MASK;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_CHANNELS_IN_USE: cfg_q.channels_in_use <= cfg_data[NCH_W-1:0];
				REG_LOW_LIMIT:       cfg_q.low_limit       <= cfg_data[SAMPLE_W-1:0];
				REG_HIGH_LIMIT:      cfg_q.high_limit      <= cfg_data[SAMPLE_W-1:0];
				REG_FAULT_COUNT:     cfg_q.fault_count     <= cfg_data[CNT_W-1:0];
				REG_FAULT_MASK:      cfg_q.fault_mask      <= cfg_data[FLAG_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/acm_channel_core.sv
module acm_channel_core import acm_pkg::*; #(
	parameter int unsigned MAX_CHANNELS = DEF_MAX_CHANNELS,
	parameter int unsigned AVG_SHIFT    = DEF_AVG_SHIFT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                step,
	input  logic [SAMPLE_W-1:0] sample,
	output res_t                res
);

	localparam int unsigned CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	logic [SUM_W-1:0]     sum_q   [MAX_CHANNELS];
	logic [AVG_W-1:0]     avg_q   [MAX_CHANNELS];
	logic [CNT_W-1:0]     orc_q   [MAX_CHANNELS];
	logic [CNT_W-1:0]     irc_q   [MAX_CHANNELS];
	logic [FLAG_W-1:0]    flags_q;
	logic [CH_W-1:0]      index_q;
	logic [AVG_SHIFT-1:0] pass_q;

	logic [CH_W-1:0]   ch;
	logic [NCMP_W-1:0] n_eff;
	logic [SUM_W:0]    sum_ext;
	logic [SUM_W-1:0]  sum_sat;
	logic [SUM_W-1:0]  avg_full;
	logic [AVG_W-1:0]  avg_sat;
	logic              pass_zero;
	logic              out_range;
	logic [CNT_W-1:0]  orc_inc;
	logic [CNT_W-1:0]  irc_inc;
	logic [CNT_W-1:0]  orc_next;
	logic [CNT_W-1:0]  irc_next;
	logic              hit;
	logic [FLAG_W-1:0] ch_bit;
	logic [FLAG_W-1:0] flags_next;
	logic              wrap;
	logic [AVG_W-1:0]  avg_next;

	always_comb begin
		ch = index_q;

		// A count of zero scans channel 0 alone; a count beyond the array is clamped.
		n_eff = (cfg.channels_in_use == '0) ? NCMP_W'(1) : NCMP_W'(cfg.channels_in_use);
		if (n_eff > NCMP_W'(MAX_CHANNELS))
			n_eff = NCMP_W'(MAX_CHANNELS);

		sum_ext   = {1'b0, sum_q[ch]} + (SUM_W+1)'(sample);
		sum_sat   = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
		avg_full  = sum_sat >> AVG_SHIFT;
		avg_sat   = (avg_full > SUM_W'(10'h3FF)) ? '1 : avg_full[AVG_W-1:0];
		pass_zero = (pass_q == '0);
		avg_next  = pass_zero ? avg_sat : avg_q[ch];

		out_range = (sample < cfg.low_limit) || (sample > cfg.high_limit);
		orc_inc   = orc_q[ch] + CNT_W'(1);
		irc_inc   = irc_q[ch] + CNT_W'(1);
		if (out_range) begin
			hit      = (orc_inc >= cfg.fault_count);
			orc_next = hit ? '0 : orc_inc;
			irc_next = '0;
		end else begin
			hit      = (irc_inc >= cfg.fault_count);
			irc_next = hit ? '0 : irc_inc;
			orc_next = '0;
		end

		// Channels at or above the width of the flag word shift the bit out entirely.
		ch_bit     = FLAG_W'(1) << ch;
		flags_next = flags_q;
		if (hit && ((cfg.fault_mask & ch_bit) != '0)) begin
			if (out_range)
				flags_next = flags_q | ch_bit;
			else
				flags_next = flags_q & ~ch_bit;
		end

		wrap = ((NCMP_W'(ch) + NCMP_W'(1)) >= n_eff);

		res.channel         = CHAN_W'(ch);
		res.sample_echo     = sample;
		res.average_updated = pass_zero;
		res.average         = avg_next;
		res.fault_flags     = flags_next;
		res.calc_ready      = wrap && pass_zero;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				sum_q[i] <= '0;
				avg_q[i] <= '0;
				orc_q[i] <= '0;
				irc_q[i] <= '0;
			end
			flags_q <= '0;
			index_q <= '0;
			pass_q  <= '0;
		end else if (step) begin
			sum_q[ch] <= pass_zero ? '0 : sum_sat;
			avg_q[ch] <= avg_next;
			orc_q[ch] <= orc_next;
			irc_q[ch] <= irc_next;
			flags_q   <= flags_next;
			if (wrap) begin
				index_q <= '0;
				pass_q  <= pass_q + AVG_SHIFT'(1);
			end else begin
				index_q <= ch + CH_W'(1);
			end
		end
	end

endmodule

// File: rtl/adc_channel_average_fault_monitor.sv
// Registers: each accepted word is held in the input register (sample_s1), and its
// channel report is registered in the result register (res_q) as the word steps on.
// Throughput: one sample per cycle while out_ready holds no stall; the per-channel
// update is a single add, compare and counter step between the two registers.
// Reset (arst_n low, asynchronous) empties both registers, clears every channel's
// sum, average and counters, the fault flags, the scan index and the pass count,
// and loads the configuration registers with their default values.
module adc_channel_average_fault_monitor import acm_pkg::*; #(
	parameter int unsigned MAX_CHANNELS = DEF_MAX_CHANNELS,
	parameter int unsigned AVG_SHIFT    = DEF_AVG_SHIFT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [SAMPLE_W-1:0]   sample,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CHAN_W-1:0]     channel,
	output logic [SAMPLE_W-1:0]   sample_echo,
	output logic                  average_updated,
	output logic [AVG_W-1:0]      average,
	output logic [FLAG_W-1:0]     fault_flags,
	output logic                  calc_ready
);

	cfg_t                cfg;
	res_t                res;
	res_t                res_q;
	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                out_valid_q;
	logic                advance;
	logic                step;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	acm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	acm_channel_core #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.AVG_SHIFT    (AVG_SHIFT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (step),
		.sample (sample_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			sample_s1 <= sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			res_q <= res;
	end

	assign out_valid       = out_valid_q;
	assign channel         = res_q.channel;
	assign sample_echo     = res_q.sample_echo;
	assign average_updated = res_q.average_updated;
	assign average         = res_q.average;
	assign fault_flags     = res_q.fault_flags;
	assign calc_ready      = res_q.calc_ready;

endmodule

// File: rtl/acm_checker.sv
module acm_checker import acm_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [CHAN_W-1:0]   channel,
	input logic [SAMPLE_W-1:0] sample_echo,
	input logic                average_updated,
	input logic [AVG_W-1:0]    average,
	input logic [FLAG_W-1:0]   fault_flags,
	input logic                calc_ready
);

	// A stalled result word holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(channel) && $stable(sample_echo)
			&& $stable(average_updated) && $stable(average) && $stable(fault_flags)
			&& $stable(calc_ready))
		else $error("result word changed while stalled");

	// The wrap pulse only comes on a pass that also refreshes the average.
	a_ready_on_update: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && calc_ready |-> average_updated)
		else $error("calc_ready without an average update");

	// Reset leaves nothing on the output.
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("output valid during reset");

	// With the output register empty, the input side cannot be stalled.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && $past(!out_valid) && $past(!in_valid) |-> in_ready)
		else $error("input stalled with the pipeline empty");

endmodule

bind adc_channel_average_fault_monitor acm_checker u_acm_checker (.*);

// File: tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import acm_pkg::*;

	typedef enum {RUN_IN_RANGE, RUN_OUT_OF_RANGE, RUN_ANY, RUN_EDGES} run_kind_t;

	class channel_report_check;
		cfg_t                       settings;
		logic [SUM_W-1:0]           sums       [DEF_MAX_CHANNELS];
		logic [AVG_W-1:0]           averages   [DEF_MAX_CHANNELS];
		logic [CNT_W-1:0]           out_runs   [DEF_MAX_CHANNELS];
		logic [CNT_W-1:0]           in_runs    [DEF_MAX_CHANNELS];
		logic [FLAG_W-1:0]          flags;
		logic [CHAN_W-1:0]          scan_index;
		logic [DEF_AVG_SHIFT-1:0]   pass_count;
		res_t                       awaited[$];
		int unsigned                mismatches;
		int unsigned                samples_taken;
		int unsigned                reports_seen;
		int unsigned                new_averages;
		int unsigned                wraps_ready;
		int unsigned                saturations;
		int unsigned                flag_changes;

		function new();
			settings = '{RST_CHANNELS, RST_LOW_LIMIT, RST_HIGH_LIMIT, RST_FAULT_CNT,
				RST_FAULT_MASK};
			foreach (sums[i]) begin
				sums[i] = '0;
				averages[i] = '0;
				out_runs[i] = '0;
				in_runs[i] = '0;
			end
			flags = '0;
			scan_index = '0;
			pass_count = '0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				REG_CHANNELS_IN_USE: settings.channels_in_use = d[NCH_W-1:0];
				REG_LOW_LIMIT:       settings.low_limit = d[SAMPLE_W-1:0];
				REG_HIGH_LIMIT:      settings.high_limit = d[SAMPLE_W-1:0];
				REG_FAULT_COUNT:     settings.fault_count = d[CNT_W-1:0];
				REG_FAULT_MASK:      settings.fault_mask = d[FLAG_W-1:0];
				default: ;
			endcase
		endfunction

		// Works out the report for one accepted word and advances the scan.
		function void take_sample(logic [SAMPLE_W-1:0] s);
			res_t              r;
			int unsigned       span;
			int unsigned       acc;
			logic [CHAN_W-1:0] ch;
			logic [FLAG_W-1:0] old_flags;

			ch = scan_index;
			old_flags = flags;
			span = settings.channels_in_use;
			if (span == 0)
				span = 1;
			if (span > DEF_MAX_CHANNELS)
				span = DEF_MAX_CHANNELS;

			acc = sums[ch] + s;
			if (acc > 16'hFFFF) begin
				acc = 16'hFFFF;
				saturations++;
			end
			sums[ch] = SUM_W'(acc);
			r.average_updated = 1'b0;
			if (pass_count == 0) begin
				acc = acc >> DEF_AVG_SHIFT;
				if (acc > 1023)
					acc = 1023;
				averages[ch] = AVG_W'(acc);
				sums[ch] = '0;
				r.average_updated = 1'b1;
				new_averages++;
			end

			if (s < settings.low_limit || s > settings.high_limit) begin
				in_runs[ch] = '0;
				out_runs[ch] = out_runs[ch] + 1'b1;
				if (out_runs[ch] >= settings.fault_count) begin
					out_runs[ch] = '0;
					if (settings.fault_mask[ch])
						flags[ch] = 1'b1;
				end
			end else begin
				out_runs[ch] = '0;
				in_runs[ch] = in_runs[ch] + 1'b1;
				if (in_runs[ch] >= settings.fault_count) begin
					in_runs[ch] = '0;
					if (settings.fault_mask[ch])
						flags[ch] = 1'b0;
				end
			end
			if (flags != old_flags)
				flag_changes++;

			r.channel = ch;
			r.sample_echo = s;
			r.average = averages[ch];
			r.fault_flags = flags;
			r.calc_ready = 1'b0;
			// An index past a lowered channel count still ends the scan here.
			if (ch + 1 >= span) begin
				scan_index = '0;
				if (pass_count == 0) begin
					r.calc_ready = 1'b1;
					wraps_ready++;
				end
				pass_count = pass_count + 1'b1;
			end else begin
				scan_index = ch + 1'b1;
			end
			awaited.push_back(r);
			samples_taken++;
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_report(res_t got);
			res_t want;
			if (awaited.size() == 0) begin
				$error("channel report on channel %0d arrived with none awaited", got.channel);
				mismatches++;
				return;
			end
			want = awaited.pop_front();
			reports_seen++;
			compare_field("channel", want.channel, got.channel);
			compare_field("sample_echo", want.sample_echo, got.sample_echo);
			compare_field("average_updated", want.average_updated, got.average_updated);
			compare_field("average", want.average, got.average);
			compare_field("fault_flags", want.fault_flags, got.fault_flags);
			compare_field("calc_ready", want.calc_ready, got.calc_ready);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [SAMPLE_W-1:0]   sample;
	logic                  out_valid;
	logic                  out_ready;
	logic [CHAN_W-1:0]     channel;
	logic [SAMPLE_W-1:0]   sample_echo;
	logic                  average_updated;
	logic [AVG_W-1:0]      average;
	logic [FLAG_W-1:0]     fault_flags;
	logic                  calc_ready;

	channel_report_check book;
	bit                  idling_on = 1'b1;
	int unsigned         settings_applied;

	adc_channel_average_fault_monitor dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			book.check_report({channel, sample_echo, average_updated, average, fault_flags,
				calc_ready});
	end

	// The receiving side stalls in bursts while idling is enabled.
	initial begin
		int unsigned hold;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (idling_on && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				hold = $urandom_range(1, 12);
			end else begin
				out_ready <= 1'b1;
				hold = $urandom_range(1, 24);
			end
			repeat (hold) @(negedge clk);
		end
	end

	initial begin
		#4_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic cfg_t settings_of(int chans, int lo, int hi, int cnt, int mask);
		cfg_t c;
		c.channels_in_use = NCH_W'(chans);
		c.low_limit = SAMPLE_W'(lo);
		c.high_limit = SAMPLE_W'(hi);
		c.fault_count = CNT_W'(cnt);
		c.fault_mask = FLAG_W'(mask);
		return c;
	endfunction

	function automatic cfg_t random_settings();
		int chans, lo, hi, cnt, mask;
		case ($urandom_range(0, 9))
			0: chans = 0;
			1: chans = 15;
			2: chans = 8;
			3: chans = 1;
			default: chans = $urandom_range(1, 8);
		endcase
		case ($urandom_range(0, 7))
			0: begin
				lo = 0;
				hi = 1023;
			end
			1: begin
				lo = $urandom_range(512, 1023);
				hi = $urandom_range(0, lo - 1);
			end
			2: begin
				lo = $urandom_range(0, 1023);
				hi = lo;
			end
			default: begin
				lo = $urandom_range(0, 400);
				hi = $urandom_range(600, 1023);
			end
		endcase
		case ($urandom_range(0, 7))
			0: cnt = 0;
			1: cnt = 127;
			2: cnt = 1;
			default: cnt = $urandom_range(1, 6);
		endcase
		case ($urandom_range(0, 5))
			0: mask = 0;
			1: mask = 255;
			default: mask = $urandom_range(0, 255);
		endcase
		return settings_of(chans, lo, hi, cnt, mask);
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample(run_kind_t kind);
		int unsigned lo, hi;
		lo = book.settings.low_limit;
		hi = book.settings.high_limit;
		case (kind)
			RUN_IN_RANGE:
				if (lo <= hi)
					return SAMPLE_W'($urandom_range(hi, lo));
			RUN_OUT_OF_RANGE: begin
				if (lo > 0 && (hi == 1023 || $urandom_range(0, 1) == 1))
					return SAMPLE_W'($urandom_range(lo - 1, 0));
				if (hi < 1023)
					return SAMPLE_W'($urandom_range(1023, hi + 1));
			end
			RUN_EDGES:
				case ($urandom_range(0, 5))
					0: return '0;
					1: return '1;
					2: return SAMPLE_W'(lo - 1);
					3: return SAMPLE_W'(lo);
					4: return SAMPLE_W'(hi);
					default: return SAMPLE_W'(hi + 1);
				endcase
			default: ;
		endcase
		return SAMPLE_W'($urandom_range(1023, 0));
	endfunction

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_sample(input logic [SAMPLE_W-1:0] s);
		int unsigned gap;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		do
			@(posedge clk);
		while (!in_ready);
		book.take_sample(s);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (book.awaited.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Writes all five registers plus one write to an index outside the map.
	task automatic apply_settings(input cfg_t c);
		logic [CFG_IDX_W-1:0]  idx [6];
		logic [CFG_DATA_W-1:0] val [6];
		idx[0] = REG_CHANNELS_IN_USE;
		idx[1] = REG_LOW_LIMIT;
		idx[2] = REG_HIGH_LIMIT;
		idx[3] = REG_FAULT_COUNT;
		idx[4] = REG_FAULT_MASK;
		idx[5] = REG_FAULT_MASK + CFG_IDX_W'($urandom_range(1, 3));
		foreach (val[k])
			val[k] = CFG_DATA_W'($urandom);
		val[0][NCH_W-1:0] = c.channels_in_use;
		val[1] = c.low_limit;
		val[2] = c.high_limit;
		val[3][CNT_W-1:0] = c.fault_count;
		val[4][FLAG_W-1:0] = c.fault_mask;
		for (int k = 0; k < 6; k++) begin
			cfg_write <= 1'b1;
			cfg_index <= idx[k];
			cfg_data <= val[k];
			@(posedge clk);
			book.write_register(idx[k], val[k]);
			@(negedge clk);
		end
		cfg_write <= 1'b0;
		settings_applied++;
	endtask

	task automatic drive_until(input int pass_goal, input int index_goal, input int lo,
		input int hi);
		while (!((pass_goal < 0 || book.pass_count == pass_goal) &&
			book.scan_index == index_goal))
			send_sample(SAMPLE_W'($urandom_range(hi, lo)));
	endtask

	initial begin
		int unsigned random_items;
		int unsigned phase_len;
		int unsigned run_left;
		int unsigned waited;
		run_kind_t   kind;

		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		sample = '0;
		book = new();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Default settings: extremes and both sides of each limit.
		send_sample(10'd0);
		send_sample(10'd1023);
		send_sample(10'd4);
		send_sample(10'd5);
		send_sample(10'd1000);
		send_sample(10'd1001);

		// A single word sets or clears a flag on every masked channel.
		wait_idle();
		apply_settings(settings_of(2, 10, 1000, 1, 8'hFF));
		send_sample(10'd0);
		send_sample(10'd1023);
		send_sample(10'd500);
		send_sample(10'd500);
		send_sample(10'd9);
		send_sample(10'd1001);

		// Zero channels behaves as one; crossed limits make every word out of range,
		// and a zero fault count fires on every word.
		wait_idle();
		apply_settings(settings_of(0, 1023, 0, 0, 8'hFF));
		send_sample(10'd512);
		send_sample(10'd0);
		send_sample(10'd1023);
		send_sample(10'd700);

		// A channel count above the maximum saturates; no channel is masked.
		wait_idle();
		apply_settings(settings_of(15, 0, 1023, 127, 8'h00));
		send_sample(10'd0);
		send_sample(10'd1023);
		send_sample(10'd341);
		send_sample(10'd682);
		send_sample(10'd1);

		// Starve channel 1 of its clearing pass so that its sum saturates: it is left
		// beyond a lowered count while pass zero goes by on channel 0 alone.
		wait_idle();
		apply_settings(settings_of(1, 5, 1000, 3, 8'h03));
		drive_until(0, 0, 1000, 1023);
		wait_idle();
		apply_settings(settings_of(2, 5, 1000, 3, 8'h03));
		drive_until(63, 1, 1000, 1023);
		wait_idle();
		apply_settings(settings_of(1, 5, 1000, 3, 8'h03));
		send_sample(SAMPLE_W'($urandom_range(1023, 1000)));
		send_sample(SAMPLE_W'($urandom_range(1023, 1000)));
		wait_idle();
		apply_settings(settings_of(2, 5, 1000, 3, 8'h03));
		drive_until(0, 1, 1000, 1023);
		send_sample(SAMPLE_W'($urandom_range(1023, 1000)));

		random_items = 0;
		run_left = 0;
		kind = RUN_ANY;
		while (random_items < 1200) begin
			if (random_items >= 1050)
				idling_on = 1'b0;
			wait_idle();
			apply_settings(random_settings());
			phase_len = $urandom_range(40, 120);
			for (int k = 0; k < phase_len; k++) begin
				if (run_left == 0) begin
					kind = run_kind_t'($urandom_range(0, 3));
					run_left = $urandom_range(1, 40);
				end
				send_sample(pick_sample(kind));
				run_left--;
				random_items++;
			end
		end

		in_valid <= 1'b0;
		waited = 0;
		while (book.awaited.size() != 0 && waited < 5000) begin
			@(negedge clk);
			waited++;
		end
		repeat (8) @(negedge clk);
		if (book.awaited.size() != 0) begin
			$error("%0d channel reports never arrived", book.awaited.size());
			book.mismatches++;
		end

		$display("Sent %0d samples under %0d register settings; checked %0d reports.",
			book.samples_taken, settings_applied, book.reports_seen);
		$display("Saw %0d new averages, %0d calc_ready wraps, %0d flag changes, %0d saturated sums.",
			book.new_averages, book.wraps_ready, book.flag_changes, book.saturations);
		if (book.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: adc_channel_average_fault_monitor.f
rtl/acm_pkg.sv
rtl/acm_cfg_regs.sv
rtl/acm_channel_core.sv
rtl/adc_channel_average_fault_monitor.sv
rtl/acm_checker.sv
tb/testbench.sv
